// ===== rtl/renc_pkg.sv =====
// Package for the RV64I instruction encoder: mnemonic codes, base opcodes,
// funct tables, layout and error enums, and the structs passed between stages.
// Depends on nothing.
package renc_pkg;

	// Mnemonic codes that bound each group of the input code space.
	localparam logic [5:0] MN_ADD   = 6'd0;
	localparam logic [5:0] MN_AND   = 6'd9;
	localparam logic [5:0] MN_ADDI  = 6'd10;
	localparam logic [5:0] MN_ANDI  = 6'd15;
	localparam logic [5:0] MN_SLLI  = 6'd16;
	localparam logic [5:0] MN_SRLI  = 6'd17;
	localparam logic [5:0] MN_SRAI  = 6'd18;
	localparam logic [5:0] MN_LB    = 6'd19;
	localparam logic [5:0] MN_LD    = 6'd22;
	localparam logic [5:0] MN_JALR  = 6'd23;
	localparam logic [5:0] MN_SB    = 6'd24;
	localparam logic [5:0] MN_SD    = 6'd27;
	localparam logic [5:0] MN_BEQ   = 6'd28;
	localparam logic [5:0] MN_BGEU  = 6'd33;
	localparam logic [5:0] MN_LUI   = 6'd34;
	localparam logic [5:0] MN_AUIPC = 6'd35;
	localparam logic [5:0] MN_JAL   = 6'd36;

	// Major opcodes of the base ISA.
	localparam logic [6:0] OPC_OP     = 7'h33;
	localparam logic [6:0] OPC_OPIMM  = 7'h13;
	localparam logic [6:0] OPC_LOAD   = 7'h03;
	localparam logic [6:0] OPC_JALR   = 7'h67;
	localparam logic [6:0] OPC_STORE  = 7'h23;
	localparam logic [6:0] OPC_BRANCH = 7'h63;
	localparam logic [6:0] OPC_LUI    = 7'h37;
	localparam logic [6:0] OPC_AUIPC  = 7'h17;
	localparam logic [6:0] OPC_JAL    = 7'h6f;
	localparam logic [6:0] F7_ALT     = 7'h20;

	localparam logic [2:0] F3_ZERO = 3'd0;
	localparam logic [2:0] F3_SLL  = 3'd1;
	localparam logic [2:0] F3_SR   = 3'd5;

	localparam logic [2:0] R_F3 [10] = '{3'd0, 3'd0, 3'd1, 3'd2, 3'd3,
		3'd4, 3'd5, 3'd5, 3'd6, 3'd7};
	// Set for sub and sra, which carry the alternate funct7.
	localparam logic R_ALT [10] = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0,
		1'b0, 1'b0, 1'b1, 1'b0, 1'b0};
	localparam logic [2:0] IA_F3 [6] = '{3'd0, 3'd2, 3'd3, 3'd4, 3'd6, 3'd7};
	localparam logic [2:0] BR_F3 [6] = '{3'd0, 3'd1, 3'd4, 3'd5, 3'd6, 3'd7};

	typedef enum logic [2:0] {
		FMT_NONE  = 3'd0,
		FMT_R     = 3'd1,
		FMT_I     = 3'd2,
		FMT_SHIFT = 3'd3,
		FMT_S     = 3'd4,
		FMT_B     = 3'd5,
		FMT_U     = 3'd6,
		FMT_J     = 3'd7
	} fmt_t;

	typedef enum logic [2:0] {
		ERR_OK    = 3'd0,
		ERR_IMM   = 3'd1,
		ERR_SHAMT = 3'd2,
		ERR_RANGE = 3'd3,
		ERR_ALIGN = 3'd4
	} err_t;

	typedef struct packed {
		fmt_t        fmt;
		logic [6:0]  base_opc;
		logic [2:0]  funct3;
		logic        alt;
		logic [4:0]  rd;
		logic [4:0]  rs1;
		logic [4:0]  rs2;
		logic [31:0] imm;
		logic [31:0] rel;
	} dec_t;

	typedef struct packed {
		dec_t dec;
		err_t err;
	} chk_t;

	localparam int IN_BITS  = 88;
	localparam int OUT_BITS = 40;

endpackage

// ===== rtl/rv64i_instruction_encoder.sv =====
// RV64I instruction encoder, top level: three-stage pipeline of decode, check and pack.
// An accepted item is registered in the decode, then check, then pack stage before output.
// Throughput is one item per cycle while the output takes items; each stage holds one
// item and advances when the stage after it is empty or moving, so bubbles close up
// behind a stalled output. Reset clears the three stage valid bits; payload registers
// are not reset. Depends on renc_pkg, renc_decode, renc_check and renc_pack.
module rv64i_instruction_encoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [5:0] opcode, [10:6] dest_reg, [15:11] src1_reg, [20:16] src2_reg,
	// [52:21] immediate, [84:53] rel_offset, [87:85] zero
	input  logic [renc_pkg::IN_BITS-1:0]  s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [31:0] machine_word, [34:32] error_code, [39:35] zero
	output logic [renc_pkg::OUT_BITS-1:0] m_axis_tdata
);

	logic           v1;
	logic           r2;
	renc_pkg::dec_t d1;
	logic           v2;
	logic           r3;
	renc_pkg::chk_t c2;
	logic [31:0]    machine_word;
	logic [2:0]     error_code;

	renc_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.opcode     (s_axis_tdata[5:0]),
		.dest_reg   (s_axis_tdata[10:6]),
		.src1_reg   (s_axis_tdata[15:11]),
		.src2_reg   (s_axis_tdata[20:16]),
		.immediate  (s_axis_tdata[52:21]),
		.rel_offset (s_axis_tdata[84:53]),
		.out_valid  (v1),
		.out_ready  (r2),
		.out_data   (d1)
	);

	renc_check u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v1),
		.in_ready  (r2),
		.in_data   (d1),
		.out_valid (v2),
		.out_ready (r3),
		.out_data  (c2)
	);

	renc_pack u_pack (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (v2),
		.in_ready     (r3),
		.in_data      (c2),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.machine_word (machine_word),
		.error_code   (error_code)
	);

	assign m_axis_tdata = {5'd0, error_code, machine_word};

endmodule

// ===== rtl/renc_decode.sv =====
// First pipeline stage of the RV64I encoder: decodes the mnemonic into layout,
// major opcode, funct3 and funct7 selection. Depends on renc_pkg.
module renc_decode (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [5:0]       opcode,
	input  logic [4:0]       dest_reg,
	input  logic [4:0]       src1_reg,
	input  logic [4:0]       src2_reg,
	input  logic [31:0]      immediate,
	input  logic [31:0]      rel_offset,
	output logic             out_valid,
	input  logic             out_ready,
	output renc_pkg::dec_t   out_data
);

	logic           valid_s1;
	renc_pkg::dec_t dec_s1;
	renc_pkg::dec_t dec_nx;
	logic [5:0]     off_r;
	logic [5:0]     off_ia;
	logic [5:0]     off_ld;
	logic [5:0]     off_st;
	logic [5:0]     off_br;

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_data  = dec_s1;

	assign off_r  = opcode - renc_pkg::MN_ADD;
	assign off_ia = opcode - renc_pkg::MN_ADDI;
	assign off_ld = opcode - renc_pkg::MN_LB;
	assign off_st = opcode - renc_pkg::MN_SB;
	assign off_br = opcode - renc_pkg::MN_BEQ;

	always_comb begin
		dec_nx          = '0;
		dec_nx.fmt      = renc_pkg::FMT_NONE;
		dec_nx.rd       = dest_reg;
		dec_nx.rs1      = src1_reg;
		dec_nx.rs2      = src2_reg;
		dec_nx.imm      = immediate;
		dec_nx.rel      = rel_offset;
		case (opcode) inside
			[renc_pkg::MN_ADD:renc_pkg::MN_AND]: begin
				dec_nx.fmt      = renc_pkg::FMT_R;
				dec_nx.base_opc = renc_pkg::OPC_OP;
				dec_nx.funct3   = renc_pkg::R_F3[off_r[3:0]];
				dec_nx.alt      = renc_pkg::R_ALT[off_r[3:0]];
			end
			[renc_pkg::MN_ADDI:renc_pkg::MN_ANDI]: begin
				dec_nx.fmt      = renc_pkg::FMT_I;
				dec_nx.base_opc = renc_pkg::OPC_OPIMM;
				dec_nx.funct3   = renc_pkg::IA_F3[off_ia[2:0]];
			end
			[renc_pkg::MN_SLLI:renc_pkg::MN_SRAI]: begin
				dec_nx.fmt      = renc_pkg::FMT_SHIFT;
				dec_nx.base_opc = renc_pkg::OPC_OPIMM;
				dec_nx.funct3   = (opcode == renc_pkg::MN_SLLI) ?
					renc_pkg::F3_SLL : renc_pkg::F3_SR;
				dec_nx.alt      = (opcode == renc_pkg::MN_SRAI);
			end
			[renc_pkg::MN_LB:renc_pkg::MN_LD]: begin
				dec_nx.fmt      = renc_pkg::FMT_I;
				dec_nx.base_opc = renc_pkg::OPC_LOAD;
				dec_nx.funct3   = off_ld[2:0];
			end
			renc_pkg::MN_JALR: begin
				dec_nx.fmt      = renc_pkg::FMT_I;
				dec_nx.base_opc = renc_pkg::OPC_JALR;
				dec_nx.funct3   = renc_pkg::F3_ZERO;
			end
			[renc_pkg::MN_SB:renc_pkg::MN_SD]: begin
				dec_nx.fmt      = renc_pkg::FMT_S;
				dec_nx.base_opc = renc_pkg::OPC_STORE;
				dec_nx.funct3   = off_st[2:0];
			end
			[renc_pkg::MN_BEQ:renc_pkg::MN_BGEU]: begin
				dec_nx.fmt      = renc_pkg::FMT_B;
				dec_nx.base_opc = renc_pkg::OPC_BRANCH;
				dec_nx.funct3   = renc_pkg::BR_F3[off_br[2:0]];
			end
			renc_pkg::MN_LUI: begin
				dec_nx.fmt      = renc_pkg::FMT_U;
				dec_nx.base_opc = renc_pkg::OPC_LUI;
			end
			renc_pkg::MN_AUIPC: begin
				dec_nx.fmt      = renc_pkg::FMT_U;
				dec_nx.base_opc = renc_pkg::OPC_AUIPC;
			end
			renc_pkg::MN_JAL: begin
				dec_nx.fmt      = renc_pkg::FMT_J;
				dec_nx.base_opc = renc_pkg::OPC_JAL;
			end
			default: begin
				dec_nx.fmt = renc_pkg::FMT_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			dec_s1 <= dec_nx;
		end
	end

endmodule

// ===== rtl/renc_check.sv =====
// Second pipeline stage of the RV64I encoder: immediate width, shift amount,
// offset range and offset alignment checks. Depends on renc_pkg.
module renc_check (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  renc_pkg::dec_t in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output renc_pkg::chk_t out_data
);

	logic           valid_s2;
	renc_pkg::chk_t chk_s2;
	renc_pkg::err_t err_nx;
	logic           imm_fits12;
	logic           shamt_ok;
	logic           rel_fits13;
	logic           rel_fits21;

	assign in_ready  = !valid_s2 || out_ready;
	assign out_valid = valid_s2;
	assign out_data  = chk_s2;

	// A value fits n signed bits when every bit from n-1 upward equals the sign.
	assign imm_fits12 = (in_data.imm[31:11] == {21{in_data.imm[31]}});
	assign shamt_ok   = (in_data.imm[31:6] == 26'd0);
	assign rel_fits13 = (in_data.rel[31:12] == {20{in_data.rel[31]}});
	assign rel_fits21 = (in_data.rel[31:20] == {12{in_data.rel[31]}});

	always_comb begin
		err_nx = renc_pkg::ERR_OK;
		case (in_data.fmt)
			renc_pkg::FMT_I, renc_pkg::FMT_S: begin
				if (!imm_fits12) err_nx = renc_pkg::ERR_IMM;
			end
			renc_pkg::FMT_SHIFT: begin
				if (!shamt_ok) err_nx = renc_pkg::ERR_SHAMT;
			end
			renc_pkg::FMT_B: begin
				if (!rel_fits13) err_nx = renc_pkg::ERR_RANGE;
				else if (in_data.rel[0]) err_nx = renc_pkg::ERR_ALIGN;
			end
			renc_pkg::FMT_J: begin
				if (!rel_fits21) err_nx = renc_pkg::ERR_RANGE;
				else if (in_data.rel[0]) err_nx = renc_pkg::ERR_ALIGN;
			end
			default: begin
				err_nx = renc_pkg::ERR_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			chk_s2.dec <= in_data;
			chk_s2.err <= err_nx;
		end
	end

endmodule

// ===== rtl/renc_pack.sv =====
// Third pipeline stage of the RV64I encoder: places the fields into the chosen
// layout and forces the word to zero on error. Depends on renc_pkg.
module renc_pack (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  renc_pkg::chk_t in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [31:0]    machine_word,
	output logic [2:0]     error_code
);

	logic           valid_s3;
	logic [31:0]    word_s3;
	renc_pkg::err_t err_s3;
	renc_pkg::dec_t d;
	logic [31:0]    word_nx;
	logic [6:0]     f7;

	assign d         = in_data.dec;
	assign in_ready  = !valid_s3 || out_ready;
	assign out_valid = valid_s3;
	assign machine_word = word_s3;
	assign error_code   = err_s3;

	assign f7 = d.alt ? renc_pkg::F7_ALT : 7'd0;

	always_comb begin
		case (d.fmt)
			renc_pkg::FMT_R:
				word_nx = {f7, d.rs2, d.rs1, d.funct3, d.rd, d.base_opc};
			renc_pkg::FMT_I:
				word_nx = {d.imm[11:0], d.rs1, d.funct3, d.rd, d.base_opc};
			renc_pkg::FMT_SHIFT:
				// Bit 5 of the shift amount sits in the lowest funct7 bit.
				word_nx = {f7 | {6'd0, d.imm[5]}, d.imm[4:0], d.rs1, d.funct3,
					d.rd, d.base_opc};
			renc_pkg::FMT_S:
				word_nx = {d.imm[11:5], d.rs2, d.rs1, d.funct3, d.imm[4:0],
					d.base_opc};
			renc_pkg::FMT_B:
				word_nx = {d.rel[12], d.rel[10:5], d.rs2, d.rs1, d.funct3,
					d.rel[4:1], d.rel[11], d.base_opc};
			renc_pkg::FMT_U:
				word_nx = {d.imm[31:12], d.rd, d.base_opc};
			renc_pkg::FMT_J:
				word_nx = {d.rel[20], d.rel[10:1], d.rel[11], d.rel[19:12],
					d.rd, d.base_opc};
			default:
				word_nx = 32'd0;
		endcase
		if (in_data.err != renc_pkg::ERR_OK) word_nx = 32'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_s3 <= word_nx;
			err_s3  <= in_data.err;
		end
	end

endmodule

// ===== rtl/renc_checker.sv =====
// Port-level checker for the RV64I instruction encoder, with its bind statement.
// Depends on renc_pkg and on the port list of rv64i_instruction_encoder.
module renc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [renc_pkg::OUT_BITS-1:0] m_axis_tdata
);

	// A result that is not taken stays on the port unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output item changed while stalled");

	// With the output side ready every stage can move, so an offered item is taken.
	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && m_axis_tready |-> s_axis_tready)
		else $error("input item refused while the output side was ready");

	// Any flagged error comes with an all-zero word.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[34:32] != renc_pkg::ERR_OK)
		|-> (m_axis_tdata[31:0] == 32'd0))
		else $error("error item carries a non-zero word");

	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[34:32] <= renc_pkg::ERR_ALIGN)
			&& (m_axis_tdata[39:35] == 5'd0))
		else $error("error code out of range or padding set");

	// A good non-zero word always carries one of the major opcodes of the base set.
	a_opc: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[34:32] == renc_pkg::ERR_OK)
			&& (m_axis_tdata[31:0] != 32'd0)
		|-> (m_axis_tdata[6:0] == renc_pkg::OPC_OP)
			|| (m_axis_tdata[6:0] == renc_pkg::OPC_OPIMM)
			|| (m_axis_tdata[6:0] == renc_pkg::OPC_LOAD)
			|| (m_axis_tdata[6:0] == renc_pkg::OPC_JALR)
			|| (m_axis_tdata[6:0] == renc_pkg::OPC_STORE)
			|| (m_axis_tdata[6:0] == renc_pkg::OPC_BRANCH)
			|| (m_axis_tdata[6:0] == renc_pkg::OPC_LUI)
			|| (m_axis_tdata[6:0] == renc_pkg::OPC_AUIPC)
			|| (m_axis_tdata[6:0] == renc_pkg::OPC_JAL))
		else $error("encoded word has an unknown major opcode");

endmodule

bind rv64i_instruction_encoder renc_checker u_renc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
